>>> rtl/core/itar_pkg.sv
`default_nettype none

package itar_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int RADIX_W     = 6;
    localparam int BYTES_W     = 4;
    localparam int CH_W        = 7;
    localparam int CNT_W       = 7;
    localparam int MAX_DIGITS  = 64;
    localparam int MAX_RESULTS = 63;
    localparam int DIG_AW      = $clog2(MAX_DIGITS);

    // The divider retires this many quotient bits per cycle.
    localparam int DIV_BITS    = 8;
    localparam int DIV_STEPS   = VALUE_WIDTH / DIV_BITS;
    localparam int DSTEP_W     = $clog2(DIV_STEPS);

    localparam int PC_W        = 4;
    localparam logic [PC_W-1:0] PC_WAIT = '0;

    localparam logic [CH_W-1:0]    CH_DIGIT0  = 7'd48;
    localparam logic [CH_W-1:0]    CH_LETTER  = 7'd55;
    localparam logic [CH_W-1:0]    CH_MINUS   = 7'd45;
    localparam logic [RADIX_W-1:0] DEC_RADIX  = 6'd10;
    localparam logic [RADIX_W-1:0] MIN_RADIX  = 6'd2;

    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_LOAD,
        UOP_PUT_ZERO,
        UOP_CLR_DIV,
        UOP_DIV_STEP,
        UOP_STORE,
        UOP_PUT_SIGN,
        UOP_READ,
        UOP_PUT_DIGIT
    } t_uop;

    typedef enum logic [3:0] {
        COND_ALWAYS,
        COND_NEVER,
        COND_NO_IN,
        COND_Q_NZ,
        COND_DIV_END,
        COND_BIT_MORE,
        COND_NO_MINUS,
        COND_OUT_BUSY,
        COND_N_ZERO
    } t_cond;

    typedef struct packed {
        t_uop             op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    typedef struct packed {
        logic q_nz;
        logic div_end;
        logic bit_more;
        logic minus;
        logic out_busy;
        logic n_zero;
    } t_dp_status;

endpackage

`default_nettype wire

>>> rtl/core/integer_to_ascii_radix_core.sv
// Each digit costs a clear, divider steps over all 64 bits (8 quotient bits each) and a store.
// Each digit character costs a test, a digit memory read, the output load and a jump.
// One item at a time.
// Reset (i_rst_n low at a clock edge) returns the sequencer to its wait step.
`default_nettype none

module integer_to_ascii_radix_core
    import itar_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [63:0] value, [69:64] radix, [73:70] type_bytes, [79:74] zero
    input  wire logic [79:0] i_s_tdata,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [6:0] ch, [7] zero
    output logic [7:0]       o_m_tdata,
    output logic             o_m_tlast
);

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          uword;
    t_dp_status      status;
    logic            take;
    logic [CH_W-1:0] ch;

    itar_ucode_rom u_rom (
        .i_pc    (r_pc),
        .o_uword (uword)
    );

    itar_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_uop        (uword.op),
        .i_in_valid   (i_s_tvalid),
        .i_value      (i_s_tdata[VALUE_WIDTH-1:0]),
        .i_radix      (i_s_tdata[VALUE_WIDTH +: RADIX_W]),
        .i_type_bytes (i_s_tdata[VALUE_WIDTH+RADIX_W +: BYTES_W]),
        .i_out_ready  (i_m_tready),
        .o_in_ready   (o_s_tready),
        .o_out_valid  (o_m_tvalid),
        .o_ch         (ch),
        .o_last       (o_m_tlast),
        .o_status     (status)
    );

    assign o_m_tdata = {1'b0, ch};

    always_comb begin
        case (uword.cond)
            COND_ALWAYS:   take = 1'b1;
            COND_NEVER:    take = 1'b0;
            COND_NO_IN:    take = !i_s_tvalid;
            COND_Q_NZ:     take = status.q_nz;
            COND_DIV_END:  take = status.div_end;
            COND_BIT_MORE: take = status.bit_more;
            COND_NO_MINUS: take = !status.minus;
            COND_OUT_BUSY: take = status.out_busy;
            COND_N_ZERO:   take = status.n_zero;
            default:       take = 1'b0;
        endcase
        n_pc = take ? uword.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/itar_ucode_rom.sv
`default_nettype none

module itar_ucode_rom
    import itar_pkg::*;
(
    input  wire logic [PC_W-1:0] i_pc,
    output t_uword               o_uword
);

    localparam logic [PC_W-1:0] PC_ZCHK   = 4'd1;
    localparam logic [PC_W-1:0] PC_ZERO   = 4'd2;
    localparam logic [PC_W-1:0] PC_LOOP   = 4'd3;
    localparam logic [PC_W-1:0] PC_DIV    = 4'd4;
    localparam logic [PC_W-1:0] PC_STORE  = 4'd5;
    localparam logic [PC_W-1:0] PC_SIGNQ  = 4'd6;
    localparam logic [PC_W-1:0] PC_SIGN   = 4'd7;
    localparam logic [PC_W-1:0] PC_EMITQ  = 4'd8;
    localparam logic [PC_W-1:0] PC_READ   = 4'd9;
    localparam logic [PC_W-1:0] PC_DIGIT  = 4'd10;
    localparam logic [PC_W-1:0] PC_BACK   = 4'd11;

    always_comb begin
        case (i_pc)
            PC_WAIT:  o_uword = '{op: UOP_LOAD,      cond: COND_NO_IN,    target: PC_WAIT};
            PC_ZCHK:  o_uword = '{op: UOP_NOP,       cond: COND_Q_NZ,     target: PC_LOOP};
            PC_ZERO:  o_uword = '{op: UOP_PUT_ZERO,  cond: COND_ALWAYS,   target: PC_EMITQ};
            PC_LOOP:  o_uword = '{op: UOP_CLR_DIV,   cond: COND_DIV_END,  target: PC_SIGNQ};
            PC_DIV:   o_uword = '{op: UOP_DIV_STEP,  cond: COND_BIT_MORE, target: PC_DIV};
            PC_STORE: o_uword = '{op: UOP_STORE,     cond: COND_ALWAYS,   target: PC_LOOP};
            PC_SIGNQ: o_uword = '{op: UOP_NOP,       cond: COND_NO_MINUS, target: PC_EMITQ};
            PC_SIGN:  o_uword = '{op: UOP_PUT_SIGN,  cond: COND_OUT_BUSY, target: PC_SIGN};
            PC_EMITQ: o_uword = '{op: UOP_NOP,       cond: COND_N_ZERO,   target: PC_WAIT};
            PC_READ:  o_uword = '{op: UOP_READ,      cond: COND_NEVER,    target: PC_WAIT};
            PC_DIGIT: o_uword = '{op: UOP_PUT_DIGIT, cond: COND_OUT_BUSY, target: PC_DIGIT};
            PC_BACK:  o_uword = '{op: UOP_NOP,       cond: COND_ALWAYS,   target: PC_EMITQ};
            default:  o_uword = '{op: UOP_NOP,       cond: COND_ALWAYS,   target: PC_WAIT};
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/itar_datapath.sv
`default_nettype none

module itar_datapath
    import itar_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  t_uop                        i_uop,
    input  wire logic                   i_in_valid,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    input  wire logic [RADIX_W-1:0]     i_radix,
    input  wire logic [BYTES_W-1:0]     i_type_bytes,
    input  wire logic                   i_out_ready,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    output logic [CH_W-1:0]             o_ch,
    output logic                        o_last,
    output t_dp_status                  o_status
);

    logic [VALUE_WIDTH-1:0] r_quot;
    logic [RADIX_W-1:0]     r_rem;
    logic [RADIX_W-1:0]     r_base;
    logic [CNT_W-1:0]       r_limit;
    logic [CNT_W-1:0]       r_n;
    logic                   r_minus;
    logic [DSTEP_W-1:0]     r_dstep;
    logic [RADIX_W-1:0]     r_rd;
    logic                   r_out_valid;
    logic [CH_W-1:0]        r_ch;
    logic                   r_last;

    logic [RADIX_W-1:0]     r_digits [MAX_DIGITS];

    logic                   out_free;
    logic                   out_load;
    logic                   load;
    logic                   in_neg;
    logic [RADIX_W-1:0]     in_base;
    logic                   signed_form;
    logic [VALUE_WIDTH-1:0] n_quot;
    logic [RADIX_W-1:0]     n_rem;
    logic [CH_W-1:0]        digit_ch;

    assign out_free    = !r_out_valid || i_out_ready;
    assign out_load    = ((i_uop == UOP_PUT_SIGN) || (i_uop == UOP_PUT_DIGIT)) && out_free;
    assign o_in_ready  = (i_uop == UOP_LOAD);
    assign load        = o_in_ready && i_in_valid;
    assign in_neg      = i_value[VALUE_WIDTH-1];
    assign in_base     = (i_radix < MIN_RADIX) ? MIN_RADIX : i_radix;
    // Decimal negatives and all non-negatives print sign and magnitude.
    assign signed_form = !in_neg || (in_base == DEC_RADIX);

    // Restoring division, DIV_BITS quotient bits per cycle. The dividend
    // shifts out of r_quot at the top while quotient bits enter at the bottom.
    always_comb begin
        logic [RADIX_W:0] t;
        n_rem  = r_rem;
        n_quot = r_quot;
        for (int k = 0; k < DIV_BITS; k++) begin
            t      = {n_rem, n_quot[VALUE_WIDTH-1]};
            n_quot = {n_quot[VALUE_WIDTH-2:0], 1'b0};
            if (t >= {1'b0, r_base}) begin
                n_rem     = RADIX_W'(t - {1'b0, r_base});
                n_quot[0] = 1'b1;
            end else begin
                n_rem = t[RADIX_W-1:0];
            end
        end
    end

    assign digit_ch = (r_rd < RADIX_W'(DEC_RADIX)) ? CH_DIGIT0 + CH_W'(r_rd)
                                                   : CH_LETTER + CH_W'(r_rd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_n         <= '0;
            r_dstep     <= '0;
            r_quot      <= '0;
            r_minus     <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_uop)
                UOP_LOAD: begin
                    if (load) begin
                        r_base <= in_base;
                        r_n    <= '0;
                        if (signed_form) begin
                            r_quot  <= in_neg ? (~i_value + 1'b1) : i_value;
                            r_minus <= in_neg;
                            r_limit <= in_neg ? CNT_W'(MAX_RESULTS - 1)
                                              : CNT_W'(MAX_RESULTS);
                        end else begin
                            r_quot  <= i_value;
                            r_minus <= 1'b0;
                            r_limit <= CNT_W'({i_type_bytes, 1'b0});
                        end
                    end
                end
                UOP_PUT_ZERO: begin
                    r_n <= CNT_W'(1);
                end
                UOP_CLR_DIV: begin
                    r_rem   <= '0;
                    r_dstep <= '0;
                end
                UOP_DIV_STEP: begin
                    r_rem   <= n_rem;
                    r_quot  <= n_quot;
                    r_dstep <= r_dstep + 1'b1;
                end
                UOP_STORE: begin
                    r_n <= r_n + 1'b1;
                end
                UOP_PUT_SIGN: begin
                    if (out_free) begin
                        r_ch   <= CH_MINUS;
                        r_last <= (r_n == '0);
                    end
                end
                UOP_PUT_DIGIT: begin
                    if (out_free) begin
                        r_ch   <= digit_ch;
                        r_last <= (r_n == CNT_W'(1));
                        r_n    <= r_n - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Digit memory: least significant digit at entry zero.
    always_ff @(posedge i_clk) begin
        if (i_uop == UOP_PUT_ZERO) begin
            r_digits[0] <= '0;
        end else if (i_uop == UOP_STORE) begin
            r_digits[r_n[DIG_AW-1:0]] <= r_rem;
        end
        if (i_uop == UOP_READ) begin
            r_rd <= r_digits[DIG_AW'(r_n - 1'b1)];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_ch              = r_ch;
    assign o_last            = r_last;
    assign o_status.q_nz     = (r_quot != '0);
    assign o_status.div_end  = (r_quot == '0) || (r_n >= r_limit);
    assign o_status.bit_more = (r_dstep != DSTEP_W'(DIV_STEPS - 1));
    assign o_status.minus    = r_minus;
    assign o_status.out_busy = !out_free;
    assign o_status.n_zero   = (r_n == '0);

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CNT_W'(MAX_RESULTS))
        else $error("digit count beyond the result limit");

    a_rem_below_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(i_uop == UOP_DIV_STEP) |-> r_rem < r_base)
        else $error("divider remainder not below the radix");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_uop == UOP_PUT_DIGIT) |-> (r_n != '0))
        else $error("digit emitted with an empty digit store");
`endif

endmodule

`default_nettype wire
